[hdl/scso_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package scso_pkg;

  localparam int unsigned CfgIndexWidth = 4;
  localparam int unsigned CfgDataWidth  = 24;
  localparam int unsigned SampleWidth   = 16;
  localparam int unsigned MulWidth      = 32;
  localparam int unsigned CountWidth    = 3;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgFramesPerControl = 4'd0,
    CfgPhaseStepPerHz   = 4'd1
  } cfg_index_e;

  localparam logic [3:0]  ResetFramesPerControl = 4'd2;
  localparam logic [23:0] ResetPhaseStep        = 24'd97391;
  localparam logic [31:0] ResetIncrement        = 32'd42852040;
  localparam logic [15:0] ResetAmplitude        = 16'd52429;
  localparam logic [3:0]  MaxFramesPerControl   = 4'd8;

  localparam logic [25:0] HzBaseQ16 = 26'd6553600;
  localparam logic [25:0] HzSpan    = 26'd900;

  localparam logic [63:0] TwoPiQ30  = 64'd6746518852;
  localparam logic [32:0] PiQ30     = 33'd3373259426;
  localparam logic [32:0] HalfPiQ30 = 33'd1686629713;
  localparam logic [2:0]  TaylorTerms = 3'd5;
  localparam logic [31:0] SineScale   = 32'd32767;

endpackage

`default_nettype wire

[hdl/scso_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface scso_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] freq_sample;
  logic [15:0] amp_sample;

  modport source (output valid, output freq_sample, output amp_sample, input ready);
  modport sink (input valid, input freq_sample, input amp_sample, output ready);
endinterface

`default_nettype wire

[hdl/scso_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface scso_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

`default_nettype wire

[hdl/scso_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface scso_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [scso_pkg::CfgIndexWidth-1:0]   index;
  logic [scso_pkg::CfgDataWidth-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/scso_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module scso_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/scso_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module scso_mul (
  input  logic                             clk_i,
  input  logic [scso_pkg::MulWidth-1:0]    a_i,
  input  logic [scso_pkg::MulWidth-1:0]    b_i,
  output logic [2*scso_pkg::MulWidth-1:0]  p_o
);

  logic [2*scso_pkg::MulWidth-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= {{scso_pkg::MulWidth{1'b0}}, a_i} * {{scso_pkg::MulWidth{1'b0}}, b_i};
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[hdl/scso_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module scso_div (
  input  logic [2:0]                      k_i,
  input  logic [scso_pkg::MulWidth-1:0]   num_i,
  input  logic [2*scso_pkg::MulWidth-1:0] prod_i,
  output logic [scso_pkg::MulWidth-1:0]   op_o,
  output logic [scso_pkg::MulWidth-1:0]   recip_o,
  output logic [scso_pkg::MulWidth-1:0]   quot_o
);

  // The denominator (2k)(2k+1) is 2^s times an odd factor d. The dividend is shifted
  // right by s and multiplied by ceil(2^(31+l) / d) with l = clog2(d); the product
  // shifted right by 31+l is the exact quotient.
  always_comb begin
    unique case (k_i)
      3'd1: begin
        op_o    = {1'b0, num_i[31:1]};
        recip_o = 32'd2863311531;
        quot_o  = {1'b0, prod_i[63:33]};
      end
      3'd2: begin
        op_o    = {2'b0, num_i[31:2]};
        recip_o = 32'd3435973837;
        quot_o  = {2'b0, prod_i[63:34]};
      end
      3'd3: begin
        op_o    = {1'b0, num_i[31:1]};
        recip_o = 32'd3272356036;
        quot_o  = {4'b0, prod_i[63:36]};
      end
      3'd4: begin
        op_o    = {3'b0, num_i[31:3]};
        recip_o = 32'd3817748708;
        quot_o  = {3'b0, prod_i[63:35]};
      end
      3'd5: begin
        op_o    = {1'b0, num_i[31:1]};
        recip_o = 32'd2498890064;
        quot_o  = {5'b0, prod_i[63:37]};
      end
      default: begin
        op_o    = '0;
        recip_o = '0;
        quot_o  = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/sensor_controlled_sine_oscillator.sv]
// Sensor-controlled sine oscillator. Each input word on in_i carries a frequency
// and an amplitude sensor reading; each one yields exactly one audio word on out_o.
// Every frames_per_control words the readings are latched as a new phase increment
// and amplitude; the sample is amplitude times the tabled sine of a 32-bit phase.
// Registers are written on cfg_i, which is always ready; write only while idle.
// After reset the block builds its sine table in RAM with the shared multiplier,
// one entry at a time; in_i is not ready during that pass. Afterwards each word
// accepted on in_i takes three passes through the shared multiplier, then the output
// step, and then the idle step that takes the next word, so the block takes no new
// word before it is through with the last one. The result sits in an output register:
// a new input word is taken while it waits, but that word's result holds in the last
// step until out_o is free, so a stalled receiver stops the block after one more word.
`timescale 1ns / 1ps
`default_nettype none

module sensor_controlled_sine_oscillator #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scso_cfg_if.sink   cfg_i,
  scso_in_if.sink    in_i,
  scso_out_if.source out_o
);

  localparam int unsigned AddrWidth = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned RemWidth  = AddrWidth + 2;
  localparam logic [63:0] QStep     = scso_pkg::TwoPiQ30 / 64'(SINE_TABLE_DEPTH);
  localparam logic [63:0] RStep     = scso_pkg::TwoPiQ30 % 64'(SINE_TABLE_DEPTH);
  localparam logic [AddrWidth-1:0] LastIdx = AddrWidth'(SINE_TABLE_DEPTH - 1);
  localparam logic [RemWidth-1:0]  DepthR  = RemWidth'(SINE_TABLE_DEPTH);

  typedef enum logic [12:0] {
    S_FOLD  = 13'b0000000000001,
    S_SQ    = 13'b0000000000010,
    S_X2    = 13'b0000000000100,
    S_TM    = 13'b0000000001000,
    S_RCP   = 13'b0000000010000,
    S_QUO   = 13'b0000000100000,
    S_SC    = 13'b0000001000000,
    S_WR    = 13'b0000010000000,
    S_IDLE  = 13'b0000100000000,
    S_IDX   = 13'b0001000000000,
    S_RD    = 13'b0010000000000,
    S_AMP   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [AddrWidth-1:0] idx_q, idx_d;
  logic [32:0]          qacc_q, qacc_d;
  logic [RemWidth-1:0]  racc_q, racc_d;
  logic [2:0]           k_q, k_d;
  logic [30:0]          x_q, x_d;
  logic                 neg_q, neg_d;
  logic [31:0]          x2_q, x2_d;
  logic [31:0]          term_q, term_d;
  logic signed [34:0]   sum_q, sum_d;

  logic [3:0]                      fpc_q, fpc_d;
  logic [23:0]                     step_q, step_d;
  logic [scso_pkg::CountWidth-1:0] fc_q, fc_d;
  logic [31:0]                     phase_q, phase_d;
  logic [31:0]                     held_inc_q, held_inc_d;
  logic [15:0]                     held_amp_q, held_amp_d;
  logic [25:0]                     hz_q, hz_d;
  logic                            latch_q, latch_d;
  logic                            sine_neg_q, sine_neg_d;
  logic                            out_valid_q, out_valid_d;
  logic [15:0]                     out_data_q, out_data_d;

  logic [scso_pkg::MulWidth-1:0]   mul_a, mul_b;
  logic [2*scso_pkg::MulWidth-1:0] mul_p;
  logic [scso_pkg::MulWidth-1:0]   rcp_op;
  logic [scso_pkg::MulWidth-1:0]   rcp_mul;
  logic [scso_pkg::MulWidth-1:0]   quotient;

  logic                 ram_we;
  logic [15:0]          ram_wdata;
  logic [15:0]          ram_rdata;
  logic [AddrWidth-1:0] ram_raddr;

  logic               in_accept;
  logic               out_load;
  logic               fold_neg;
  logic [32:0]        fold_x1;
  logic [32:0]        fold_x;
  logic [30:0]        sum_clamped;
  logic [45:0]        ent_round;
  logic [15:0]        ent_mag;
  logic [15:0]        ent_value;
  logic [15:0]        sine_abs;
  logic [50:0]        inc_round;
  logic signed [33:0] prod_s;
  logic signed [33:0] prod_biased;
  logic [25:0]        hz_new;
  logic [3:0]         fpc_eff;
  logic [3:0]         fc_inc;
  logic [RemWidth-1:0] racc_sum;

  scso_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  scso_div u_div (
    .k_i     (k_q),
    .num_i   (mul_p[61:30]),
    .prod_i  (mul_p),
    .op_o    (rcp_op),
    .recip_o (rcp_mul),
    .quot_o  (quotient)
  );

  scso_ram #(
    .WIDTH (scso_pkg::SampleWidth),
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready       = (state_q == S_IDLE);
  assign in_accept        = in_i.valid && in_i.ready;
  assign out_load         = (state_q == S_OUT) && (!out_valid_q || out_o.ready);
  assign out_o.valid      = out_valid_q;
  assign out_o.out_sample = out_data_q;
  assign cfg_i.ready      = 1'b1;

  assign fold_neg = qacc_q > scso_pkg::PiQ30;
  assign fold_x1  = fold_neg ? (qacc_q - scso_pkg::PiQ30) : qacc_q;
  assign fold_x   = (fold_x1 > scso_pkg::HalfPiQ30)
                    ? ((fold_x1 > scso_pkg::PiQ30) ? 33'd0 : (scso_pkg::PiQ30 - fold_x1))
                    : fold_x1;

  always_comb begin
    if (sum_q < 35'sd0) begin
      sum_clamped = '0;
    end else if (sum_q > 35'sd1073741824) begin
      sum_clamped = 31'd1073741824;
    end else begin
      sum_clamped = sum_q[30:0];
    end
  end

  assign ent_round = mul_p[45:0] + 46'd536870912;
  assign ent_mag   = ent_round[45:30];
  assign ent_value = neg_q ? (~ent_mag + 16'd1) : ent_mag;

  assign sine_abs    = ram_rdata[15] ? (~ram_rdata + 16'd1) : ram_rdata;
  assign inc_round   = mul_p[50:0] + 51'd32768;
  assign prod_s      = sine_neg_q ? -$signed({3'b000, mul_p[30:0]})
                                  : $signed({3'b000, mul_p[30:0]});
  assign prod_biased = prod_s + 34'sd32768;

  assign hz_new = scso_pkg::HzBaseQ16 + 26'(in_i.freq_sample) * scso_pkg::HzSpan;

  always_comb begin
    if (fpc_q == 4'd0) begin
      fpc_eff = 4'd1;
    end else if (fpc_q > scso_pkg::MaxFramesPerControl) begin
      fpc_eff = scso_pkg::MaxFramesPerControl;
    end else begin
      fpc_eff = fpc_q;
    end
  end

  assign fc_inc   = {1'b0, fc_q} + 4'd1;
  assign racc_sum = racc_q + RStep[RemWidth-1:0];

  assign ram_we    = (state_q == S_WR);
  assign ram_wdata = ent_value;
  assign ram_raddr = mul_p[32 +: AddrWidth];

  always_comb begin
    unique case (state_q)
      S_SQ: begin
        mul_a = {1'b0, x_q};
        mul_b = {1'b0, x_q};
      end
      S_TM: begin
        mul_a = term_q;
        mul_b = x2_q;
      end
      S_RCP: begin
        mul_a = rcp_op;
        mul_b = rcp_mul;
      end
      S_SC: begin
        mul_a = {1'b0, sum_clamped};
        mul_b = scso_pkg::SineScale;
      end
      S_IDX: begin
        mul_a = phase_q;
        mul_b = 32'(SINE_TABLE_DEPTH);
      end
      S_RD: begin
        mul_a = {6'b0, hz_q};
        mul_b = {8'b0, step_q};
      end
      S_AMP: begin
        mul_a = {16'b0, held_amp_q};
        mul_b = {17'b0, sine_abs[14:0]};
      end
      S_OUT: begin
        mul_a = mul_p[31:0];
        mul_b = 32'd1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    qacc_d      = qacc_q;
    racc_d      = racc_q;
    k_d         = k_q;
    x_d         = x_q;
    neg_d       = neg_q;
    x2_d        = x2_q;
    term_d      = term_q;
    sum_d       = sum_q;
    fpc_d       = fpc_q;
    step_d      = step_q;
    fc_d        = fc_q;
    phase_d     = phase_q;
    held_inc_d  = held_inc_q;
    held_amp_d  = held_amp_q;
    hz_d        = hz_q;
    latch_d     = latch_q;
    sine_neg_d  = sine_neg_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_i.valid) begin
      if (cfg_i.index == scso_pkg::CfgFramesPerControl) begin
        fpc_d = cfg_i.data[3:0];
      end else if (cfg_i.index == scso_pkg::CfgPhaseStepPerHz) begin
        step_d = cfg_i.data;
      end
    end

    unique case (state_q)
      S_FOLD: begin
        x_d     = fold_x[30:0];
        neg_d   = fold_neg;
        state_d = S_SQ;
      end
      S_SQ: begin
        state_d = S_X2;
      end
      S_X2: begin
        x2_d    = mul_p[61:30];
        term_d  = {1'b0, x_q};
        sum_d   = $signed({4'b0000, x_q});
        k_d     = 3'd1;
        state_d = S_TM;
      end
      S_TM: begin
        state_d = S_RCP;
      end
      S_RCP: begin
        state_d = S_QUO;
      end
      S_QUO: begin
        term_d = quotient;
        if (k_q[0]) begin
          sum_d = sum_q - $signed({3'b000, quotient});
        end else begin
          sum_d = sum_q + $signed({3'b000, quotient});
        end
        if (k_q == scso_pkg::TaylorTerms) begin
          state_d = S_SC;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_TM;
        end
      end
      S_SC: begin
        state_d = S_WR;
      end
      S_WR: begin
        idx_d = idx_q + AddrWidth'(1);
        if (racc_sum >= DepthR) begin
          racc_d = racc_sum - DepthR;
          qacc_d = qacc_q + QStep[32:0] + 33'd1;
        end else begin
          racc_d = racc_sum;
          qacc_d = qacc_q + QStep[32:0];
        end
        state_d = (idx_q == LastIdx) ? S_IDLE : S_FOLD;
      end
      S_IDLE: begin
        if (in_accept) begin
          hz_d    = hz_new;
          latch_d = (fc_q == '0);
          if (fc_q == '0) begin
            held_amp_d = in_i.amp_sample;
          end
          fc_d    = (fc_inc >= fpc_eff) ? '0 : fc_inc[scso_pkg::CountWidth-1:0];
          state_d = S_IDX;
        end
      end
      S_IDX: begin
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_AMP;
      end
      S_AMP: begin
        if (latch_q) begin
          held_inc_d = inc_round[47:16];
        end
        sine_neg_d = ram_rdata[15];
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          phase_d     = phase_q + held_inc_q;
          out_data_d  = prod_biased[31:16];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_FOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FOLD;
      idx_q       <= '0;
      qacc_q      <= '0;
      racc_q      <= '0;
      k_q         <= 3'd1;
      fpc_q       <= scso_pkg::ResetFramesPerControl;
      step_q      <= scso_pkg::ResetPhaseStep;
      fc_q        <= '0;
      phase_q     <= '0;
      held_inc_q  <= scso_pkg::ResetIncrement;
      held_amp_q  <= scso_pkg::ResetAmplitude;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      qacc_q      <= qacc_d;
      racc_q      <= racc_d;
      k_q         <= k_d;
      fpc_q       <= fpc_d;
      step_q      <= step_d;
      fc_q        <= fc_d;
      phase_q     <= phase_d;
      held_inc_q  <= held_inc_d;
      held_amp_q  <= held_amp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    neg_q      <= neg_d;
    x2_q       <= x2_d;
    term_q     <= term_d;
    sum_q      <= sum_d;
    hz_q       <= hz_d;
    latch_q    <= latch_d;
    sine_neg_q <= sine_neg_d;
    out_data_q <= out_data_d;
  end

  a_taylor_term_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RCP) || (state_q == S_QUO))
      |-> ((k_q != 3'd0) && (k_q <= scso_pkg::TaylorTerms)))
    else $error("Taylor term index out of range during division.");

  a_table_write_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !in_i.ready)
    else $error("Sine table written while input is ready.");

  a_accept_starts_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_IDX))
    else $error("Accepted word did not start the sample sequence.");

  a_output_blocked_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_OUT) && !out_load) |=> ((state_q == S_OUT) && out_o.valid))
    else $error("Blocked result left its final step.");

endmodule

`default_nettype wire

[bench/scso_sample_check.sv]
`timescale 1ns / 1ps

module scso_sample_check #(
  parameter int unsigned TableDepth = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scso_cfg_if         cfg_i,
  scso_in_if          in_i,
  scso_out_if         out_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  localparam longint Q30One = 64'sd1073741824;

  logic signed [15:0] sine_rom [TableDepth];

  logic [3:0]  frames_setting;
  logic [23:0] step_per_hz;
  logic [31:0] osc_phase;
  int unsigned frame_index;
  logic [31:0] held_step;
  logic [15:0] held_gain;

  logic signed [15:0] expected_samples [$];
  logic signed [15:0] want;
  int unsigned        errors;

  // Rounded 32767 * sin(2*pi*i/depth), built in Q30 with a truncated Taylor series.
  function automatic logic signed [15:0] sine_value(input int unsigned i);
    logic [63:0]        angle;
    logic [63:0]        angle_sq;
    logic [63:0]        term;
    longint             sum;
    logic               negative;
    logic signed [15:0] magnitude;
    angle = (64'(i) * scso_pkg::TwoPiQ30) / 64'(TableDepth);
    negative = 1'b0;
    if (angle > 64'(scso_pkg::PiQ30)) begin
      negative = 1'b1;
      angle = angle - 64'(scso_pkg::PiQ30);
    end
    if (angle > 64'(scso_pkg::HalfPiQ30)) begin
      angle = (angle > 64'(scso_pkg::PiQ30)) ? 64'd0 : 64'(scso_pkg::PiQ30) - angle;
    end
    angle_sq = (angle * angle) >> 30;
    term = angle;
    sum = longint'(angle);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * angle_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > Q30One) begin
      sum = Q30One;
    end
    sum = (sum * longint'(scso_pkg::SineScale) + Q30One / 2) / Q30One;
    magnitude = sum[15:0];
    return negative ? -magnitude : magnitude;
  endfunction

  function automatic logic signed [15:0] next_sample(input logic [15:0] freq,
                                                      input logic [15:0] amp);
    int unsigned limit;
    logic [63:0] rate_q16;
    logic [63:0] step;
    int unsigned idx;
    longint      product;
    limit = frames_setting;
    if (limit == 0) begin
      limit = 1;
    end
    if (limit > scso_pkg::MaxFramesPerControl) begin
      limit = scso_pkg::MaxFramesPerControl;
    end
    if (frame_index == 0) begin
      rate_q16 = 64'(scso_pkg::HzBaseQ16) + 64'(scso_pkg::HzSpan) * 64'(freq);
      step = (rate_q16 * 64'(step_per_hz) + 64'd32768) >> 16;
      held_step = step[31:0];
      held_gain = amp;
    end
    frame_index = frame_index + 1;
    if (frame_index >= limit) begin
      frame_index = 0;
    end
    frame_index = frame_index & 7;
    idx = int'((64'(osc_phase) * 64'(TableDepth)) >> 32);
    if (idx >= TableDepth) begin
      idx = TableDepth - 1;
    end
    product = longint'(held_gain) * longint'(sine_rom[idx]);
    product = (product + 32768) >>> 16;
    osc_phase = osc_phase + held_step;
    return product[15:0];
  endfunction

  initial begin
    for (int i = 0; i < TableDepth; i++) begin
      sine_rom[i] = sine_value(i);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_setting = scso_pkg::ResetFramesPerControl;
      step_per_hz = scso_pkg::ResetPhaseStep;
      osc_phase = '0;
      frame_index = 0;
      held_step = scso_pkg::ResetIncrement;
      held_gain = scso_pkg::ResetAmplitude;
      expected_samples.delete();
      errors = 0;
      error_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          scso_pkg::CfgFramesPerControl: frames_setting = cfg_i.data[3:0];
          scso_pkg::CfgPhaseStepPerHz:   step_per_hz = cfg_i.data;
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        expected_samples.push_back(next_sample(in_i.freq_sample, in_i.amp_sample));
      end
      if (out_i.valid && out_i.ready) begin
        if (expected_samples.size() == 0) begin
          $error("out_sample: expected no word, got %0d", out_i.out_sample);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_i.out_sample !== want) begin
            $error("out_sample: expected %0d, got %0d", want, out_i.out_sample);
            errors++;
          end
        end
      end
      pending_o <= expected_samples.size();
      error_count_o <= errors;
    end
  end

endmodule

[bench/sensor_controlled_sine_oscillator_test.sv]
`timescale 1ns / 1ps

module sensor_controlled_sine_oscillator_test;

  localparam int unsigned ClockPeriod = 20;
  localparam int unsigned CycleLimit  = 1_200_000;
  localparam int unsigned ItemTarget  = 1650;
  localparam int unsigned CalmItems   = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  bit          idle_en = 1'b1;
  int unsigned error_count;
  int unsigned pending_words;
  int unsigned cycle_count = 0;

  scso_cfg_if cfg_bus ();
  scso_in_if  frame_bus ();
  scso_out_if sample_bus ();

  sensor_controlled_sine_oscillator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (frame_bus),
    .out_o  (sample_bus)
  );

  scso_sample_check i_sample_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_bus),
    .in_i          (frame_bus),
    .out_i         (sample_bus),
    .error_count_o (error_count),
    .pending_o     (pending_words)
  );

  always #(ClockPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CycleLimit);
    $display("sensor_controlled_sine_oscillator verification failed");
    $finish;
  end

  initial begin
    sample_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 6) == 0) begin
        sample_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      sample_bus.ready <= 1'b1;
    end
  end

  task automatic write_register(input logic [3:0] index, input logic [23:0] value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [15:0] freq, input logic [15:0] amp);
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      frame_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    frame_bus.valid       <= 1'b1;
    frame_bus.freq_sample <= freq;
    frame_bus.amp_sample  <= amp;
    do @(posedge clk_i); while (!frame_bus.ready);
  endtask

  // Waits until every sample has come back, then lets the pipeline run empty.
  task automatic drain_samples();
    @(negedge clk_i);
    frame_bus.valid <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic [15:0] sensor_reading();
    logic [15:0] value;
    case ($urandom_range(0, 7))
      0:       value = 16'h0000;
      1:       value = 16'hFFFF;
      2:       value = 16'h0001 << $urandom_range(0, 15);
      default: value = 16'($urandom());
    endcase
    return value;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    logic [3:0]  frames;
    logic [23:0] word;
    logic [23:0] step;
    bit          frames_first;

    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    frame_bus.valid = 1'b0;
    frame_bus.freq_sample = '0;
    frame_bus.amp_sample = '0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_frame(16'h0000, 16'h0000);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'h5555, 16'hAAAA);
    send_frame(16'hAAAA, 16'h5555);
    send_frame(16'h0000, 16'hFFFF);
    send_frame(16'hFFFF, 16'h0000);
    send_frame(16'h8000, 16'h8000);
    send_frame(16'h0001, 16'h0001);

    // A zero frame count latches every word; the widest step wraps the increment.
    drain_samples();
    write_register(scso_pkg::CfgFramesPerControl, 24'hFFFFF0);
    write_register(scso_pkg::CfgPhaseStepPerHz, 24'hFFFFFF);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'h0000, 16'hFFFF);
    send_frame(16'hFFFF, 16'h8000);
    send_frame(16'h1234, 16'hFFFF);

    drain_samples();
    write_register(scso_pkg::CfgFramesPerControl, 24'h00000F);
    write_register(scso_pkg::CfgPhaseStepPerHz, scso_pkg::ResetPhaseStep);
    write_register(4'(scso_pkg::CfgPhaseStepPerHz) + 4'd1, 24'h000000);
    repeat (6) send_frame(sensor_reading(), sensor_reading());

    // The frame counter now sits past the lowered frame count.
    drain_samples();
    write_register(scso_pkg::CfgFramesPerControl, 24'h000003);
    repeat (4) send_frame(sensor_reading(), sensor_reading());
    sent = 22;

    while (sent < ItemTarget) begin
      drain_samples();
      idle_en = (sent + CalmItems < ItemTarget) && ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 5))
        0:       frames = 4'd0;
        1:       frames = 4'd1;
        2:       frames = scso_pkg::MaxFramesPerControl;
        3:       frames = 4'($urandom_range(9, 15));
        default: frames = 4'($urandom_range(1, 8));
      endcase
      word = 24'($urandom());
      word[3:0] = frames;
      case ($urandom_range(0, 4))
        0:       step = 24'h000000;
        1:       step = 24'hFFFFFF;
        2:       step = scso_pkg::ResetPhaseStep;
        default: step = 24'($urandom());
      endcase
      frames_first = $urandom_range(0, 1);
      if (frames_first && $urandom_range(0, 3) != 0) begin
        write_register(scso_pkg::CfgFramesPerControl, word);
      end
      if ($urandom_range(0, 3) != 0) begin
        write_register(scso_pkg::CfgPhaseStepPerHz, step);
      end
      if (!frames_first && $urandom_range(0, 3) != 0) begin
        write_register(scso_pkg::CfgFramesPerControl, word);
      end
      if ($urandom_range(0, 4) == 0) begin
        write_register(4'($urandom_range(4'(scso_pkg::CfgPhaseStepPerHz) + 1, 15)),
                       24'($urandom()));
      end
      burst = $urandom_range(40, 120);
      repeat (burst) send_frame(sensor_reading(), sensor_reading());
      sent = sent + burst;
    end

    idle_en = 1'b0;
    drain_samples();
    repeat (16) @(negedge clk_i);
    if (error_count == 0) begin
      $display("sensor_controlled_sine_oscillator verification clean");
    end else begin
      $display("sensor_controlled_sine_oscillator verification failed");
    end
    $finish;
  end

endmodule
